>>> hw/rtl/dscm_pkg.sv
// Shared types and constants for the depth sigma-clip mask block.
`timescale 1ns / 1ps
`default_nettype none
package dscm_pkg;

  // Kind of a queued pixel, decided by the front end
  typedef enum logic [1:0] {
    KIND_ACC      = 2'd0,
    KIND_ACC_LAST = 2'd1,
    KIND_CLASSIFY = 2'd2
  } kind_e;

  // Configuration register indexes
  localparam logic [1:0] CFG_FILTER_MODE = 2'd0;
  localparam logic [1:0] CFG_DEV_FACTOR  = 2'd1;
  localparam logic [1:0] CFG_RANGE_LOW   = 2'd2;
  localparam logic [1:0] CFG_RANGE_HIGH  = 2'd3;

  localparam int          FACTOR_W     = 12;
  localparam logic [11:0] FACTOR_RESET = 12'd512;
  localparam int          QUEUE_DEPTH  = 4;

  // Back-end sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACC,
    ST_START,
    ST_MEAN_WAIT,
    ST_MSQ_START,
    ST_MSQ_WAIT,
    ST_SQRT_START,
    ST_SQRT_WAIT,
    ST_BOUNDS
  } back_state_e;

  // Head of the pixel queue as seen by the back end
  typedef struct packed {
    logic  valid;
    kind_e kind;
    logic  premasked;
  } head_ctl_t;

endpackage
`default_nettype wire

>>> hw/rtl/dscm_front.sv
// Front end: accepts pixels, decodes their kind and queues them for the back end.
`timescale 1ns / 1ps
`default_nettype none
module dscm_front #(
  parameter int DEPTH_BITS = 20
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  wire                          req_type_i,
  input  wire signed [DEPTH_BITS-1:0]  depth_i,
  input  wire                          premasked_i,
  input  wire                          last_i,
  output dscm_pkg::head_ctl_t          head_o,
  output logic signed [DEPTH_BITS-1:0] head_depth_o,
  input  wire                          pop_i
);
  import dscm_pkg::*;

  localparam int ENT_W = DEPTH_BITS + 3;
  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [ENT_W-1:0] entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push;
  kind_e            kind;
  logic [ENT_W-1:0] head_ent;

  // Decode the kind of the incoming pixel
  always_comb begin
    if (req_type_i) begin
      kind = KIND_CLASSIFY;
    end else if (last_i) begin
      kind = KIND_ACC_LAST;
    end else begin
      kind = KIND_ACC;
    end
  end

  assign in_ready_o = (count_q != CNT_W'(QUEUE_DEPTH));
  assign push       = in_valid_i && in_ready_o;

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + PTR_W'(1) : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop_i) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop_i && !push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the queued pixel
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= {kind, premasked_i, depth_i};
    end
  end

  // Present the head of the queue
  assign head_ent            = entry_q[rd_ptr_q];
  assign head_o.valid        = (count_q != '0);
  assign head_o.kind         = kind_e'(head_ent[ENT_W-1:ENT_W-2]);
  assign head_o.premasked    = head_ent[DEPTH_BITS];
  assign head_depth_o        = head_ent[DEPTH_BITS-1:0];

endmodule
`default_nettype wire

>>> hw/rtl/dscm_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module dscm_div #(
  parameter int NUM_W = 42,
  parameter int DEN_W = 21
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              start_i,
  input  wire [NUM_W-1:0]  num_i,
  input  wire [DEN_W-1:0]  den_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);
  localparam int CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quot_q;
  logic [DEN_W-1:0] rem_q, den_q;
  logic [CW-1:0]    cnt_q;
  logic             busy_q, done_q;
  logic [DEN_W:0]   trial;
  logic             fits;

  // Shift in the next dividend bit and try the subtraction
  assign trial = {rem_q, quot_q[NUM_W-1]};
  assign fits  = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= num_i;
      den_q  <= den_i;
      rem_q  <= '0;
    end else if (busy_q) begin
      quot_q <= {quot_q[NUM_W-2:0], fits};
      rem_q  <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule
`default_nettype wire

>>> hw/rtl/dscm_isqrt.sv
// Integer square root, one result bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module dscm_isqrt #(
  parameter int IN_W = 60
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             start_i,
  input  wire [IN_W-1:0]                  val_i,
  output logic                            done_o,
  output logic [(IN_W + IN_W % 2)/2-1:0]  root_o
);
  localparam int RW    = IN_W + IN_W % 2;
  localparam int OUT_W = RW / 2;
  localparam int CW    = $clog2(OUT_W + 1);

  logic [RW-1:0] rem_q, res_q, bit_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic [RW:0]   trial;
  logic          fits;

  assign trial = {1'b0, res_q} + {1'b0, bit_q};
  assign fits  = ({1'b0, rem_q} >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(OUT_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // One digit-by-digit root step per cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= RW'(val_i);
      res_q <= '0;
      bit_q <= RW'(1) << (RW - 2);
    end else if (busy_q) begin
      if (fits) begin
        rem_q <= rem_q - trial[RW-1:0];
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = res_q[OUT_W-1:0];

endmodule
`default_nettype wire

>>> hw/rtl/dscm_back.sv
// Back end: accumulates statistics, derives the bounds and classifies pixels.
`timescale 1ns / 1ps
`default_nettype none
module dscm_back #(
  parameter int DEPTH_BITS = 20,
  parameter int MAX_PIXELS = 1048576
) (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  dscm_pkg::head_ctl_t                    head_i,
  input  wire signed [DEPTH_BITS-1:0]            head_depth_i,
  output logic                                   pop_o,
  input  wire                                    filter_mode_i,
  input  wire [dscm_pkg::FACTOR_W-1:0]           factor_i,
  input  wire signed [DEPTH_BITS-1:0]            range_low_i,
  input  wire signed [DEPTH_BITS-1:0]            range_high_i,
  output logic                                   out_valid_o,
  input  wire                                    out_ready_i,
  output logic                                   masked_o
);
  import dscm_pkg::*;

  localparam int CNT_W   = $clog2(MAX_PIXELS + 1);
  localparam int SUM_W   = DEPTH_BITS + CNT_W;
  localparam int SQ_FULL = 2 * DEPTH_BITS - 1 + CNT_W;
  localparam int SQ_W    = (SQ_FULL > 64) ? 64 : SQ_FULL;
  localparam int DIV_W   = (SUM_W + 1 > SQ_W) ? SUM_W + 1 : SQ_W;
  localparam int SD_W    = (SQ_W + SQ_W % 2) / 2;
  localparam int PROD_W  = FACTOR_W + SD_W;
  localparam int SPAN_W  = PROD_W + 1 - 8;
  localparam int SBW     = PROD_W + 2;
  localparam int BND_W   = DEPTH_BITS + 1;

  localparam logic [CNT_W-1:0]        MAX_CNT = CNT_W'(MAX_PIXELS);
  localparam logic signed [BND_W-1:0] BND_MIN = {1'b1, {DEPTH_BITS{1'b0}}};
  localparam logic signed [BND_W-1:0] BND_MAX = {1'b0, {DEPTH_BITS{1'b1}}};

  back_state_e state_q, state_d;

  logic signed [SUM_W-1:0]      sum_q;
  logic [SQ_W-1:0]              sqsum_q;
  logic [CNT_W-1:0]             count_q;
  logic [2*DEPTH_BITS-1:0]      sq_q;
  logic                         sq_add_q, last_q;
  logic [DEPTH_BITS-1:0]        mmag_q;
  logic [2*DEPTH_BITS-1:0]      m2_q;
  logic [SQ_W-1:0]              var_q;
  logic [PROD_W-1:0]            prod_q;
  logic signed [BND_W-1:0]      lower_q, upper_q;
  logic                         out_valid_q, out_mask_q;

  logic                         is_cls, counted, out_free;
  logic [DEPTH_BITS-1:0]        pix_mag;
  logic                         sum_neg;
  logic [SUM_W-1:0]             sum_mag;
  logic [DIV_W-1:0]             div_num;
  logic                         div_start, div_busy, div_done;
  logic [DIV_W-1:0]             div_quot;
  logic                         sqrt_start, sqrt_done;
  logic [SD_W-1:0]              sqrt_root;
  logic [SQ_W-1:0]              msq;
  logic [PROD_W:0]              prod_rnd;
  logic [SPAN_W-1:0]            span;
  logic signed [SBW-1:0]        mean_s, lo_s, hi_s, bmin_s, bmax_s;
  logic signed [BND_W-1:0]      lo_sat, hi_sat, cls_lo, cls_hi, pix_ext;
  logic                         cls_mask;

  // Classify the queue head
  assign is_cls   = (head_i.kind == KIND_CLASSIFY);
  assign counted  = !head_i.premasked && (count_q < MAX_CNT);
  assign out_free = !out_valid_q || out_ready_i;
  assign pix_mag  = head_depth_i[DEPTH_BITS-1] ? DEPTH_BITS'(-head_depth_i)
                                               : DEPTH_BITS'(head_depth_i);
  assign pix_ext  = {head_depth_i[DEPTH_BITS-1], head_depth_i};
  assign cls_lo   = filter_mode_i ? {range_low_i[DEPTH_BITS-1], range_low_i} : lower_q;
  assign cls_hi   = filter_mode_i ? {range_high_i[DEPTH_BITS-1], range_high_i} : upper_q;
  assign cls_mask = head_i.premasked || (pix_ext < cls_lo) || (pix_ext > cls_hi);

  // Mean numerator: magnitude of the sum plus half the count for rounding
  assign sum_neg = sum_q[SUM_W-1];
  assign sum_mag = sum_neg ? SUM_W'(-sum_q) : SUM_W'(sum_q);

  // Next state, queue pop and unit launches
  always_comb begin
    state_d    = state_q;
    pop_o      = 1'b0;
    div_start  = 1'b0;
    div_num    = '0;
    sqrt_start = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (head_i.valid) begin
          if (is_cls) begin
            pop_o = out_free;
          end else begin
            pop_o   = 1'b1;
            state_d = ST_ACC;
          end
        end
      end
      ST_ACC: begin
        state_d = last_q ? ST_START : ST_IDLE;
      end
      ST_START: begin
        if (count_q == '0) begin
          state_d = ST_IDLE;
        end else begin
          div_start = 1'b1;
          div_num   = DIV_W'({1'b0, sum_mag} + (SUM_W + 1)'(count_q >> 1));
          state_d   = ST_MEAN_WAIT;
        end
      end
      ST_MEAN_WAIT: begin
        if (div_done) begin
          state_d = ST_MSQ_START;
        end
      end
      ST_MSQ_START: begin
        div_start = 1'b1;
        div_num   = DIV_W'(sqsum_q);
        state_d   = ST_MSQ_WAIT;
      end
      ST_MSQ_WAIT: begin
        if (div_done) begin
          state_d = ST_SQRT_START;
        end
      end
      ST_SQRT_START: begin
        sqrt_start = 1'b1;
        state_d    = ST_SQRT_WAIT;
      end
      ST_SQRT_WAIT: begin
        if (sqrt_done) begin
          state_d = ST_BOUNDS;
        end
      end
      ST_BOUNDS: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Iterative units; the divider is shared by the mean and mean-square divisions
  dscm_div #(
    .NUM_W (DIV_W),
    .DEN_W (CNT_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (count_q),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  dscm_isqrt #(
    .IN_W (SQ_W)
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .val_i   (var_q),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  // Bounds: mean -/+ rounded span, saturated
  assign msq      = div_quot[SQ_W-1:0];
  assign prod_rnd = {1'b0, prod_q} + (PROD_W + 1)'(128);
  assign span     = prod_rnd[PROD_W:8];
  assign mean_s   = last_q ? -SBW'(mmag_q) : SBW'(mmag_q);
  assign lo_s     = mean_s - SBW'(span);
  assign hi_s     = mean_s + SBW'(span);
  assign bmin_s   = {{(SBW-BND_W){BND_MIN[BND_W-1]}}, BND_MIN};
  assign bmax_s   = {{(SBW-BND_W){BND_MAX[BND_W-1]}}, BND_MAX};
  assign lo_sat   = (lo_s < bmin_s) ? BND_MIN : ((lo_s > bmax_s) ? BND_MAX : lo_s[BND_W-1:0]);
  assign hi_sat   = (hi_s < bmin_s) ? BND_MIN : ((hi_s > bmax_s) ? BND_MAX : hi_s[BND_W-1:0]);

  // Statistics registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q    <= '0;
      sqsum_q  <= '0;
      count_q  <= '0;
      sq_add_q <= 1'b0;
      last_q   <= 1'b0;
      lower_q  <= BND_MIN;
      upper_q  <= BND_MAX;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (pop_o && !is_cls) begin
            sq_add_q <= counted;
            last_q   <= (head_i.kind == KIND_ACC_LAST);
            if (counted) begin
              sum_q   <= sum_q + SUM_W'(head_depth_i);
              count_q <= count_q + CNT_W'(1);
            end
          end
        end
        ST_ACC: begin
          if (sq_add_q) begin
            sqsum_q <= sqsum_q + SQ_W'(sq_q);
          end
        end
        ST_START: begin
          // hold the sign of the sum for the mean
          last_q <= sum_neg;
          if (count_q == '0) begin
            lower_q <= BND_MIN;
            upper_q <= BND_MAX;
            sum_q   <= '0;
            sqsum_q <= '0;
          end
        end
        ST_BOUNDS: begin
          lower_q <= lo_sat;
          upper_q <= hi_sat;
          sum_q   <= '0;
          sqsum_q <= '0;
          count_q <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath registers: pixel square, mean magnitude, its square, variance and scaled deviation
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE) begin
      sq_q <= pix_mag * pix_mag;
    end
    if (state_q == ST_MEAN_WAIT && div_done) begin
      mmag_q <= div_quot[DEPTH_BITS-1:0];
    end
    if (state_q == ST_MSQ_START) begin
      m2_q <= mmag_q * mmag_q;
    end
    if (state_q == ST_MSQ_WAIT && div_done) begin
      var_q <= (msq > SQ_W'(m2_q)) ? (msq - SQ_W'(m2_q)) : '0;
    end
    if (sqrt_done) begin
      prod_q <= factor_i * sqrt_root;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o && is_cls) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && is_cls) begin
      out_mask_q <= cls_mask;
    end
  end

  assign out_valid_o = out_valid_q;
  assign masked_o    = out_mask_q;

`ifndef SYNTHESIS
  a_count_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MAX_CNT)
    else $error("pixel count beyond limit");

  a_cls_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && is_cls) |-> (!out_valid_q || out_ready_i))
    else $error("classify result would overwrite a pending transfer");

  a_div_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider launched while busy");

  a_bounds_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BOUNDS) |=> (count_q == '0 && state_q == ST_IDLE))
    else $error("statistics not cleared after bounds update");
`endif

endmodule
`default_nettype wire

>>> hw/rtl/depth_sigma_clip_mask.sv
// Top level of the depth sigma-clip mask: config registers, front end and back end.
//
// Channel   Direction  Content
// s_axis    in         tdata: depth_value, already_masked; tuser: req_type; tlast: last_pixel
// m_axis    out        tdata: masked_out
// cfg       in         write enable, register index, write data
//
// A classify pixel is popped and classified in the idle state; an accumulate pixel
// is squared there and its square added to the sum of squares in the accumulate
// state. The last accumulate pixel starts the statistics run: with default
// parameters two restoring divisions of 60 quotient bits and a 30-step square root,
// one after the other; the back end takes no pixel until the run is over.
// A four-entry queue keeps accepting pixels while the back end works or the output
// stalls, until it is full. Reset clears all statistics; bounds start fully open.
`timescale 1ns / 1ps
`default_nettype none
module depth_sigma_clip_mask #(
  parameter int DEPTH_BITS = 20,
  parameter int MAX_PIXELS = 1048576
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   s_axis_tvalid,
  output logic                                  s_axis_tready,
  // depth_value, already_masked (from bit 0 up), zero padded to bytes
  input  wire [((DEPTH_BITS + 8) / 8) * 8 - 1:0] s_axis_tdata,
  // req_type
  input  wire                                   s_axis_tuser,
  input  wire                                   s_axis_tlast,
  output logic                                  m_axis_tvalid,
  input  wire                                   m_axis_tready,
  // masked_out in bit 0, rest zero
  output logic [7:0]                            m_axis_tdata,
  input  wire                                   cfg_we_i,
  input  wire [1:0]                             cfg_idx_i,
  input  wire [((DEPTH_BITS > 12) ? DEPTH_BITS : 12) - 1:0] cfg_wdata_i
);
  import dscm_pkg::*;

  logic                         filter_mode_q;
  logic [FACTOR_W-1:0]          factor_q;
  logic signed [DEPTH_BITS-1:0] range_low_q, range_high_q;
  head_ctl_t                    head;
  logic signed [DEPTH_BITS-1:0] head_depth;
  logic                         pop;
  logic                         masked;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_mode_q <= 1'b0;
      factor_q      <= FACTOR_RESET;
      range_low_q   <= {1'b1, {(DEPTH_BITS-1){1'b0}}};
      range_high_q  <= {1'b0, {(DEPTH_BITS-1){1'b1}}};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FILTER_MODE: filter_mode_q <= cfg_wdata_i[0];
        CFG_DEV_FACTOR:  factor_q      <= cfg_wdata_i[FACTOR_W-1:0];
        CFG_RANGE_LOW:   range_low_q   <= cfg_wdata_i[DEPTH_BITS-1:0];
        CFG_RANGE_HIGH:  range_high_q  <= cfg_wdata_i[DEPTH_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  dscm_front #(
    .DEPTH_BITS (DEPTH_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .req_type_i   (s_axis_tuser),
    .depth_i      (s_axis_tdata[DEPTH_BITS-1:0]),
    .premasked_i  (s_axis_tdata[DEPTH_BITS]),
    .last_i       (s_axis_tlast),
    .head_o       (head),
    .head_depth_o (head_depth),
    .pop_i        (pop)
  );

  dscm_back #(
    .DEPTH_BITS (DEPTH_BITS),
    .MAX_PIXELS (MAX_PIXELS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .head_depth_i  (head_depth),
    .pop_o         (pop),
    .filter_mode_i (filter_mode_q),
    .factor_i      (factor_q),
    .range_low_i   (range_low_q),
    .range_high_i  (range_high_q),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .masked_o      (masked)
  );

  assign m_axis_tdata = {7'd0, masked};

endmodule
`default_nettype wire
